@@ rtl/cma_pkg.sv @@
// Shared types and constants of the centered moving average filter.
package cma_pkg;

  // Field widths.
  localparam int SAMPLE_BITS   = 16;
  localparam int SUM_BITS      = SAMPLE_BITS + 5;
  localparam int HALF_BITS     = 4;
  localparam int RECIP_BITS    = 16;
  localparam int FRAC_BITS     = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_RECIP = 2'd1;

  // Configuration reset values.
  localparam logic [HALF_BITS-1:0]  HALF_RESET  = 4'd1;
  localparam logic [RECIP_BITS-1:0] RECIP_RESET = 16'd21845;

  // One input item.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_sample;
  } item_t;

  // One result item.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          final_output;
  } result_t;

  // Window sum handed from the window unit to the scaling unit.
  typedef struct packed {
    logic                       vld;
    logic                       last;
    logic signed [SUM_BITS-1:0] sum;
  } win_t;

  // Window unit sequencer states.
  typedef enum logic [0:0] {
    BK_SAMPLE,
    BK_FLUSH
  } bk_state_e;

endpackage

@@ rtl/cma_front.sv @@
// Input side: accepts samples and holds them in a short queue for the window unit.
module cma_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cma_pkg::item_t in_data_i,
  output logic           q_vld_o,
  output cma_pkg::item_t q_item_o,
  input  logic           pop_i
);
  import cma_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  item_t            mem_q [QDEPTH];
  logic [QPW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPW:0]     cnt_q, cnt_d;
  logic             wr, rd;

  // Transfer in whenever the queue has room.
  assign in_stall_o = (cnt_q == (QPW+1)'(QDEPTH));
  assign wr         = in_valid_i && !in_stall_o;
  assign rd         = pop_i && q_vld_o;
  assign q_vld_o    = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) begin
        wr_ptr_q <= (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd) begin
        rd_ptr_q <= (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

@@ rtl/cma_back.sv @@
// Window unit: keeps the sample line and running sum, and sequences the end-of-vector flush.
module cma_back #(
  parameter int HALF_MAX = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              q_vld_i,
  input  cma_pkg::item_t                    q_item_i,
  output logic                              pop_o,
  input  logic [cma_pkg::HALF_BITS-1:0]     half_i,
  output cma_pkg::win_t                     win_o
);
  import cma_pkg::*;

  localparam int LD   = 2 * HALF_MAX + 1;
  localparam int PW   = $clog2(LD);
  localparam int SW   = $clog2(LD + 1);
  localparam int CNTW = $clog2(HALF_MAX + 1);

  typedef logic [PW:0] ptrx_t;

  bk_state_e                     state_q, state_d;
  logic [CNTW-1:0]               cnt_q, cnt_d;
  logic [PW-1:0]                 ptr_q, ptr_d;
  logic [SW-1:0]                 seen_q, seen_d;
  logic signed [SUM_BITS-1:0]    sum_q, sum_d, sum_new;
  logic signed [SAMPLE_BITS-1:0] line_q [LD];
  logic signed [SAMPLE_BITS-1:0] push_val, drop_val;
  logic                          push, last_step, emit, drop_ok;
  ptrx_t                         kern, diff;
  logic [PW-1:0]                 old_idx;
  logic                          win_vld_q, win_last_q;
  logic signed [SUM_BITS-1:0]    win_sum_q;

  // Slot that leaves the window: 2h+1 positions behind the write pointer.
  assign kern    = ptrx_t'({half_i, 1'b1});
  assign diff    = ptrx_t'({1'b0, ptr_q}) + ptrx_t'(LD) - kern;
  assign old_idx = (int'(diff) >= LD) ? PW'(diff - ptrx_t'(LD)) : PW'(diff);

  // Slots not yet written in this vector read as zero.
  assign drop_ok  = int'(seen_q) >= int'(kern);
  assign drop_val = drop_ok ? line_q[old_idx] : '0;
  assign sum_new  = sum_q + SUM_BITS'(push_val) - SUM_BITS'(drop_val);

  // An output is due once h samples precede the one being pushed.
  assign emit = int'(seen_q) >= int'(half_i);

  // Sequencer: one sample push, then h zero pushes after a final sample.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    push      = 1'b0;
    pop_o     = 1'b0;
    last_step = 1'b0;
    push_val  = '0;
    case (state_q)
      BK_SAMPLE: begin
        if (adv_i && q_vld_i) begin
          push     = 1'b1;
          pop_o    = 1'b1;
          push_val = q_item_i.sample;
          if (q_item_i.final_sample) begin
            state_d = BK_FLUSH;
            cnt_d   = CNTW'(1);
          end
        end
      end
      BK_FLUSH: begin
        if (adv_i) begin
          push = 1'b1;
          if (int'(cnt_q) == int'(half_i)) begin
            last_step = 1'b1;
            state_d   = BK_SAMPLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = BK_SAMPLE;
      end
    endcase
  end

  // Window state after a push; the last flush step starts a fresh vector.
  always_comb begin
    sum_d  = sum_q;
    ptr_d  = ptr_q;
    seen_d = seen_q;
    if (push) begin
      if (last_step) begin
        sum_d  = '0;
        ptr_d  = '0;
        seen_d = '0;
      end else begin
        sum_d  = sum_new;
        ptr_d  = (int'(ptr_q) == LD - 1) ? '0 : ptr_q + 1'b1;
        seen_d = (int'(seen_q) == LD) ? seen_q : seen_q + 1'b1;
      end
    end
  end

  // Control and window state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_SAMPLE;
      cnt_q     <= '0;
      ptr_q     <= '0;
      seen_q    <= '0;
      sum_q     <= '0;
      win_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      seen_q  <= seen_d;
      sum_q   <= sum_d;
      if (adv_i) begin
        win_vld_q <= push && emit;
      end
    end
  end

  // Sample line and the sum handed downstream.
  always_ff @(posedge clk_i) begin
    if (push) begin
      line_q[ptr_q] <= push_val;
    end
    if (adv_i) begin
      win_last_q <= last_step;
      win_sum_q  <= sum_new;
    end
  end

  assign win_o.vld  = win_vld_q;
  assign win_o.last = win_last_q;
  assign win_o.sum  = win_sum_q;

  // The final flush step leaves an empty window behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_step |=> (seen_q == '0) && (ptr_q == '0) && (sum_q == '0))
    else $error("window not cleared after the final flush step");

  // In the flush state the flush counter stays between 1 and h.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FLUSH) |-> (int'(cnt_q) >= 1) && (int'(cnt_q) <= int'(half_i)))
    else $error("flush counter out of range");

  // The last push of a vector always carries an output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_step |-> emit)
    else $error("final flush step without an output");

  // The sample count saturates at the line depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(seen_q) <= LD)
    else $error("sample count beyond line depth");

endmodule

@@ rtl/cma_scale.sv @@
// Scaling unit: multiplies the window sum by the reciprocal, rounds, saturates and holds the result.
module cma_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cma_pkg::win_t                      win_i,
  input  logic [cma_pkg::RECIP_BITS-1:0]     recip_i,
  output logic                               adv_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output cma_pkg::result_t                   out_data_o
);
  import cma_pkg::*;

  localparam int PRODW = SUM_BITS + RECIP_BITS + 1;
  localparam int QW    = PRODW - FRAC_BITS;

  logic signed [PRODW-1:0]       prod_d, prod_q;
  logic                          p_vld_q, p_last_q;
  logic signed [QW-1:0]          quot;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                          ovf;
  logic                          out_vld_q;
  result_t                       out_q;

  // The whole pipeline moves unless a held result is stalled.
  assign adv_o = !out_vld_q || !out_stall_i;

  // Product plus one half, so an arithmetic shift rounds half up.
  assign prod_d = PRODW'(win_i.sum) * PRODW'($signed({1'b0, recip_i}))
                + PRODW'(1 << (FRAC_BITS - 1));

  // Saturate when the bits above the sample sign disagree.
  assign quot = prod_q[PRODW-1:FRAC_BITS];
  assign ovf  = (quot[QW-1:SAMPLE_BITS-1] != '0) && (quot[QW-1:SAMPLE_BITS-1] != '1);
  always_comb begin
    if (!ovf) begin
      sat = quot[SAMPLE_BITS-1:0];
    end else if (quot[QW-1]) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // Valid bits of the product and output stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv_o) begin
      p_vld_q   <= win_i.vld;
      out_vld_q <= p_vld_q;
    end
  end

  // Product and output payload.
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      prod_q             <= prod_d;
      p_last_q           <= win_i.last;
      out_q.smoothed     <= sat;
      out_q.final_output <= p_last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/centered_moving_average.sv @@
// Top level of the centered moving average filter.
// Centered boxcar filter over a streamed vector of signed 16-bit samples: output j is the
// sum of samples j-h..j+h (zero outside the vector) times the Q0.16 kernel_reciprocal,
// rounded half up and saturated. One sample is taken per cycle while in_stall_o is low; output j
// leaves once sample j+h has been taken, passing the input queue, window update, multiply and
// output register. After a sample flagged final_sample the window unit pushes h zero samples to
// flush the pending outputs, marks the last one with final_output and starts the next vector
// from an empty window; the input queue keeps taking samples meanwhile until it fills.
// half_width 0 acts as 1 and values above MAX_HALF act as MAX_HALF. Write the configuration
// only while no vector is in flight; cfg_ready_o is always high.
module centered_moving_average #(
  parameter int MAX_HALF = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cma_pkg::item_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cma_pkg::result_t                    out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cma_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [cma_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import cma_pkg::*;

  localparam int HALF_LIM = (1 << HALF_BITS) - 1;
  localparam int HMAX     = (MAX_HALF < HALF_LIM) ? MAX_HALF : HALF_LIM;

  logic [HALF_BITS-1:0]  half_q, half_eff;
  logic [RECIP_BITS-1:0] recip_q;
  logic                  q_vld, pop, adv;
  item_t                 q_item;
  win_t                  win;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= HALF_RESET;
      recip_q <= RECIP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HALF_WIDTH:   half_q  <= cfg_data_i[HALF_BITS-1:0];
        CFG_KERNEL_RECIP: recip_q <= cfg_data_i[RECIP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective half width, clamped to the supported range.
  always_comb begin
    if (half_q == '0) begin
      half_eff = HALF_BITS'(1);
    end else if (int'(half_q) > HMAX) begin
      half_eff = HALF_BITS'(HMAX);
    end else begin
      half_eff = half_q;
    end
  end

  cma_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_vld_o    (q_vld),
    .q_item_o   (q_item),
    .pop_i      (pop)
  );

  cma_back #(
    .HALF_MAX (HMAX)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .q_vld_i  (q_vld),
    .q_item_i (q_item),
    .pop_o    (pop),
    .half_i   (half_eff),
    .win_o    (win)
  );

  cma_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_i       (win),
    .recip_i     (recip_q),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
